### hdl/tun_pkg.sv
// Package for the triangle unit-normal core: widths, the cell payload type.
// Used by the channel interfaces, the root cell and the top level.
package tun_pkg;
	localparam int COORD_W = 24;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int NORMAL_W = NORMAL_FRAC_BITS + 2;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W = PROD_W;
	localparam int HALF_W = MAG_W / 2;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int RES_W = SQ_W + 2 * NORMAL_FRAC_BITS + 8;
	localparam int QW = NORMAL_FRAC_BITS + 1;
	localparam int NCELL = NORMAL_FRAC_BITS + 1;
	localparam int IDX_W = $clog2(NORMAL_FRAC_BITS + 1);
	localparam int SH_W = IDX_W + 2;
	localparam logic signed [NORMAL_W-1:0] NORMAL_ONE = NORMAL_W'(1) <<< NORMAL_FRAC_BITS;

	typedef struct packed {
		logic                     valid;
		logic                     deg;
		logic [2:0]               neg;
		logic [SUM_W-1:0]         s;
		logic [2:0][RES_W-1:0]    r;
		logic [2:0][RES_W-1:0]    tsum;
		logic [2:0][QW-1:0]       q;
	} cell_t;
endpackage

### hdl/tun_ifs.sv
// Valid/ready channel interfaces: triangle corners in, unit normal out.
// Depends on tun_pkg for the field widths.
interface tun_in_if;
	import tun_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tun_out_if;
	import tun_pkg::*;
	logic valid;
	logic ready;
	logic signed [NORMAL_W-1:0] normal_x, normal_y, normal_z;
	logic degenerate;
	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

### hdl/triangle_unit_normal_core.sv
// Top level of the triangle unit-normal core: edge differences, cross product,
// squared length, then a chain of rounding cells and the output register.
// Pipeline of 7 arithmetic stages, 15 cells and the output register.
// Throughput one triangle per cycle; the whole pipeline stalls only while a
// result waits and the sink is not ready.
// Reset (arst_n, asynchronous) clears the stage valid bits only.
module triangle_unit_normal_core (
	input  logic     clk,
	input  logic     arst_n,
	tun_in_if.sink   tri_in,
	tun_out_if.source nrm_out
);
	import tun_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_v_q;

	logic signed [DIFF_W-1:0]  cb_s1[3], ab_s1[3];
	logic signed [PROD_W-1:0]  p_s2[3], m_s2[3];
	logic [MAG_W-1:0]          mag_s3[3];
	logic [2:0]                neg_s3, neg_s4, neg_s5, neg_s6;
	logic [2*HALF_W-1:0]       hh_s4[3], hl_s4[3], ll_s4[3];
	logic [SQ_W-1:0]           sq_s5[3], sq_s6[3];
	logic [SUM_W-1:0]          s_s6;
	cell_t                     st_s7;
	cell_t                     chain[NCELL+1];
	logic signed [CROSS_W-1:0] n_d[3];
	logic [RES_W-1:0]          s_ext;
	logic [QW-1:0]             qf[3];
	logic signed [NORMAL_W-1:0] nrm_d[3];

	assign en           = !out_v_q || nrm_out.ready;
	assign tri_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= tri_in.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; out_v_q <= chain[NCELL].valid;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			n_d[c] = {p_s2[c][PROD_W-1], p_s2[c]} - {m_s2[c][PROD_W-1], m_s2[c]};
		end
		s_ext = {{(RES_W-SUM_W){1'b0}}, s_s6};
		for (int c = 0; c < 3; c++) begin
			qf[c]    = chain[NCELL].q[c];
			nrm_d[c] = chain[NCELL].neg[c] ? -$signed({1'b0, qf[c]}) : $signed({1'b0, qf[c]});
			if (chain[NCELL].deg) nrm_d[c] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cb_s1[0] <= {tri_in.c_x[COORD_W-1], tri_in.c_x} - {tri_in.b_x[COORD_W-1], tri_in.b_x};
			cb_s1[1] <= {tri_in.c_y[COORD_W-1], tri_in.c_y} - {tri_in.b_y[COORD_W-1], tri_in.b_y};
			cb_s1[2] <= {tri_in.c_z[COORD_W-1], tri_in.c_z} - {tri_in.b_z[COORD_W-1], tri_in.b_z};
			ab_s1[0] <= {tri_in.a_x[COORD_W-1], tri_in.a_x} - {tri_in.b_x[COORD_W-1], tri_in.b_x};
			ab_s1[1] <= {tri_in.a_y[COORD_W-1], tri_in.a_y} - {tri_in.b_y[COORD_W-1], tri_in.b_y};
			ab_s1[2] <= {tri_in.a_z[COORD_W-1], tri_in.a_z} - {tri_in.b_z[COORD_W-1], tri_in.b_z};

			p_s2[0] <= cb_s1[1] * ab_s1[2];
			m_s2[0] <= cb_s1[2] * ab_s1[1];
			p_s2[1] <= cb_s1[2] * ab_s1[0];
			m_s2[1] <= cb_s1[0] * ab_s1[2];
			p_s2[2] <= cb_s1[0] * ab_s1[1];
			m_s2[2] <= cb_s1[1] * ab_s1[0];

			for (int c = 0; c < 3; c++) begin
				neg_s3[c] <= n_d[c][CROSS_W-1];
				mag_s3[c] <= n_d[c][CROSS_W-1] ? MAG_W'(-n_d[c]) : MAG_W'(n_d[c]);

				hh_s4[c] <= mag_s3[c][MAG_W-1:HALF_W] * mag_s3[c][MAG_W-1:HALF_W];
				hl_s4[c] <= mag_s3[c][MAG_W-1:HALF_W] * mag_s3[c][HALF_W-1:0];
				ll_s4[c] <= mag_s3[c][HALF_W-1:0] * mag_s3[c][HALF_W-1:0];

				sq_s5[c] <= ({{(SQ_W-2*HALF_W){1'b0}}, hh_s4[c]} << MAG_W)
					+ ({{(SQ_W-2*HALF_W){1'b0}}, hl_s4[c]} << (HALF_W + 1))
					+ {{(SQ_W-2*HALF_W){1'b0}}, ll_s4[c]};
				sq_s6[c] <= sq_s5[c];
			end
			neg_s4 <= neg_s3; neg_s5 <= neg_s4; neg_s6 <= neg_s5;
			s_s6 <= {2'b00, sq_s5[0]} + {2'b00, sq_s5[1]} + {2'b00, sq_s5[2]};

			st_s7.valid <= 1'b0;
			st_s7.deg   <= (s_s6 == '0);
			st_s7.neg   <= neg_s6;
			st_s7.s     <= s_s6;
			for (int c = 0; c < 3; c++) begin
				st_s7.r[c] <= ({{(RES_W-SQ_W){1'b0}}, sq_s6[c]} << (2 * NORMAL_FRAC_BITS + 2))
					- s_ext;
				st_s7.tsum[c] <= -s_ext;
				st_s7.q[c]    <= '0;
			end

			nrm_out.normal_x   <= nrm_d[0];
			nrm_out.normal_y   <= nrm_d[1];
			nrm_out.normal_z   <= nrm_d[2];
			nrm_out.degenerate <= chain[NCELL].deg;
		end
	end

	always_comb begin
		chain[0]       = st_s7;
		chain[0].valid = v_s7;
	end

	genvar i;
	for (i = 0; i < NCELL; i++) begin : g_cell
		tun_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.bit_idx (IDX_W'(NORMAL_FRAC_BITS - i)),
			.d       (chain[i]),
			.q       (chain[i+1])
		);
	end

	assign nrm_out.valid = out_v_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_out.valid && nrm_out.degenerate |->
			nrm_out.normal_x == '0 && nrm_out.normal_y == '0 && nrm_out.normal_z == '0)
		else $error("degenerate result with non-zero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_out.valid |->
			$signed(nrm_out.normal_x) <= NORMAL_ONE && $signed(nrm_out.normal_x) >= -NORMAL_ONE &&
			$signed(nrm_out.normal_y) <= NORMAL_ONE && $signed(nrm_out.normal_y) >= -NORMAL_ONE &&
			$signed(nrm_out.normal_z) <= NORMAL_ONE && $signed(nrm_out.normal_z) >= -NORMAL_ONE)
		else $error("normal component out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !tri_in.ready |=> v_s1)
		else $error("first stage lost an item during a stall");

	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chain[NCELL].valid && !en |=> chain[NCELL].valid)
		else $error("last cell lost an item during a stall");
endmodule

### hdl/tun_cell.sv
// One cell of the rounding chain: settles one quotient bit of all three components.
// Depends on tun_pkg.
module tun_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [tun_pkg::IDX_W-1:0] bit_idx,
	input  tun_pkg::cell_t          d,
	output tun_pkg::cell_t          q
);
	import tun_pkg::*;

	logic             v_q;
	cell_t            pay_q;
	cell_t            nxt;
	logic [RES_W-1:0] s_ext;
	logic [SH_W-1:0]  sh_t, sh_s, sh_a;
	logic [RES_W-1:0] sub  [3];
	logic [RES_W-1:0] trial[3];
	logic [2:0]       take;

	always_comb begin
		nxt   = d;
		s_ext = {{(RES_W-SUM_W){1'b0}}, d.s};
		sh_t  = {2'b00, bit_idx} + SH_W'(2);
		sh_s  = {1'b0, bit_idx, 1'b0} + SH_W'(2);
		sh_a  = {2'b00, bit_idx} + SH_W'(1);
		for (int c = 0; c < 3; c++) begin
			sub[c]   = (d.tsum[c] << sh_t) + (s_ext << sh_s);
			trial[c] = d.r[c] - sub[c];
			take[c]  = ~trial[c][RES_W-1];
			if (take[c]) begin
				nxt.r[c]    = trial[c];
				nxt.tsum[c] = d.tsum[c] + (s_ext << sh_a);
				nxt.q[c]    = d.q[c] | (QW'(1) << bit_idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		q       = pay_q;
		q.valid = v_q;
	end
endmodule

### tb/tb_triangle_unit_normal_core.sv
// Testbench for triangle_unit_normal_core: random and directed triangles with
// random idling, checked against an exact integer model of the unit normal.
// Depends on tun_pkg and the channel interfaces in tun_ifs.sv.
`timescale 1ns / 100ps

module tb_triangle_unit_normal_core;
	import tun_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NORMAL_W-1:0] comp_t;
	typedef struct {
		comp_t nx, ny, nz;
		logic  deg;
	} normal_t;

	logic clk;
	logic arst_n;
	tun_in_if  tri_in();
	tun_out_if nrm_out();

	triangle_unit_normal_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tri_in (tri_in.sink),
		.nrm_out(nrm_out.source)
	);

	normal_t expected_normals[$];
	int      n_errors;
	int      n_sent;
	int      n_checked;
	int      n_deg;
	bit      rx_stall_en;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("triangle_unit_normal_core test failed");
		$finish;
	end

	// one component magnitude rounded to nearest, ties away, clamped to one
	function automatic comp_t unit_component(logic signed [255:0] n, logic [255:0] ssq);
		logic [255:0] mag, rhs, t, lhs;
		longint lo, hi, mid;
		mag = n[255] ? -n : n;
		rhs = (mag * mag) << (2 * NORMAL_FRAC_BITS + 2);
		lo = 0;
		hi = longint'(1) << NORMAL_FRAC_BITS;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			t = 256'(2 * mid - 1);
			lhs = t * t * ssq;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return n[255] ? comp_t'(-lo) : comp_t'(lo);
	endfunction

	function automatic normal_t face_normal(coord_t c[9]);
		logic signed [255:0] ab[3], cb[3], n[3];
		logic [255:0] ssq;
		normal_t r;
		for (int i = 0; i < 3; i++) begin
			ab[i] = 256'(c[i]) - 256'(c[3+i]);
			cb[i] = 256'(c[6+i]) - 256'(c[3+i]);
		end
		n[0] = cb[1] * ab[2] - cb[2] * ab[1];
		n[1] = cb[2] * ab[0] - cb[0] * ab[2];
		n[2] = cb[0] * ab[1] - cb[1] * ab[0];
		ssq = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
		if (ssq == 0) begin
			r.nx = '0; r.ny = '0; r.nz = '0; r.deg = 1'b1;
		end else begin
			r.nx = unit_component(n[0], ssq);
			r.ny = unit_component(n[1], ssq);
			r.nz = unit_component(n[2], ssq);
			r.deg = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		n_errors++;
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	task automatic send_triangle(coord_t c[9], bit idle_en);
		int gap;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			tri_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tri_in.a_x <= c[0]; tri_in.a_y <= c[1]; tri_in.a_z <= c[2];
		tri_in.b_x <= c[3]; tri_in.b_y <= c[4]; tri_in.b_z <= c[5];
		tri_in.c_x <= c[6]; tri_in.c_y <= c[7]; tri_in.c_z <= c[8];
		tri_in.valid <= 1'b1;
		expected_normals.insert(expected_normals.size(), face_normal(c));
		n_sent++;
		do @(posedge clk); while (!tri_in.ready);
	endtask

	task automatic hold_input();
		tri_in.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		normal_t want;
		if (nrm_out.valid && nrm_out.ready) begin
			if (expected_normals.size() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = expected_normals.pop_front();
				n_checked++;
				if (want.deg) n_deg++;
				if (nrm_out.normal_x !== want.nx)
					report_mismatch("normal_x", nrm_out.normal_x, want.nx);
				if (nrm_out.normal_y !== want.ny)
					report_mismatch("normal_y", nrm_out.normal_y, want.ny);
				if (nrm_out.normal_z !== want.nz)
					report_mismatch("normal_z", nrm_out.normal_z, want.nz);
				if (nrm_out.degenerate !== want.deg)
					report_mismatch("degenerate", nrm_out.degenerate, want.deg);
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int burst;
		nrm_out.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (rx_stall_en && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 11);
				nrm_out.ready <= 1'b0;
				repeat (burst) @(posedge clk);
				nrm_out.ready <= 1'b1;
			end
		end
	end

	function automatic coord_t rand_coord(int kind);
		unique case (kind)
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
			2: return $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}};
			default: return coord_t'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
		endcase
	endfunction

	task automatic test_directed();
		coord_t c[9];
		coord_t mx, mn;
		mx = {1'b0, {(COORD_W-1){1'b1}}};
		mn = {1'b1, {(COORD_W-1){1'b0}}};
		c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_triangle(c, 0);
		c = '{4096, 0, 0, 0, 0, 0, 0, 4096, 0};
		send_triangle(c, 0);
		c = '{0, 4096, 0, 0, 0, 0, 4096, 0, 0};
		send_triangle(c, 0);
		c = '{0, 0, 4096, 0, 0, 0, 0, 4096, 0};
		send_triangle(c, 0);
		c = '{mx, mx, mx, mn, mn, mn, mx, mn, mx};
		send_triangle(c, 0);
		c = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
		send_triangle(c, 0);
		c = '{mx, mx, mx, mn, mn, mn, 0, 0, 0};
		send_triangle(c, 0);
		c = '{mx, mx, mx, mx, mx, mx, 5, 6, 7};
		send_triangle(c, 0);
		c = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
		send_triangle(c, 0);
		c = '{1, 1, 0, 0, 0, 0, 0, 1, 1};
		send_triangle(c, 0);
		c = '{mn, 0, 0, 0, 0, 0, 0, mx, 0};
		send_triangle(c, 0);
		c = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
		send_triangle(c, 0);
		c = '{3, 4, 0, 0, 0, 0, 0, 0, 1};
		send_triangle(c, 0);
		c = '{1, 2, 0, 0, 0, 0, 0, 0, mx};
		send_triangle(c, 0);
		c = '{-1, 0, 0, 0, 0, 0, 0, -1, 0};
		send_triangle(c, 0);
		hold_input();
	endtask

	task automatic test_random(int count, bit idle_en);
		coord_t c[9];
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 3);
			foreach (c[j]) c[j] = rand_coord($urandom_range(0, 9) == 0 ? 2 : kind);
			if ($urandom_range(0, 19) == 0) begin
				// collinear or coincident corners
				for (int j = 0; j < 3; j++) c[6+j] = c[j];
			end
			send_triangle(c, idle_en);
		end
		hold_input();
	endtask

	task automatic drain_pipeline();
		int guard;
		guard = 0;
		while (expected_normals.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
	endtask

	initial begin
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_deg = 0;
		rx_stall_en = 1'b0;
		arst_n = 1'b0;
		tri_in.valid = 1'b0;
		{tri_in.a_x, tri_in.a_y, tri_in.a_z} = '0;
		{tri_in.b_x, tri_in.b_y, tri_in.b_z} = '0;
		{tri_in.c_x, tri_in.c_y, tri_in.c_z} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain_pipeline();
		rx_stall_en = 1'b1;
		test_random(600, 1);
		// wait for every result before resuming
		drain_pipeline();
		test_random(350, 1);
		rx_stall_en = 1'b0;
		test_random(200, 0);
		drain_pipeline();

		$display("sent %0d triangles, checked %0d normals, %0d degenerate",
			n_sent, n_checked, n_deg);
		$display("covered extreme corners, axis-aligned faces and random stalls");
		if (n_errors == 0 && expected_normals.size() == 0) begin
			$display("triangle_unit_normal_core test passed");
		end else begin
			$display("triangle_unit_normal_core test failed");
		end
		$finish;
	end
endmodule

### triangle_unit_normal_core.f
hdl/tun_pkg.sv
hdl/tun_ifs.sv
hdl/tun_cell.sv
hdl/triangle_unit_normal_core.sv
tb/tb_triangle_unit_normal_core.sv
